/* rtl/core/pso_pkg.sv */
// Package with shared types and constants for the percolation site opener.
package pso_pkg;

    localparam int MAX_SIDE = 32;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE + 2;
    localparam int AW       = $clog2(DEPTH);
    localparam int SW       = $clog2(MAX_SIDE + 1);

    localparam logic FN_CLEAR = 1'b0;
    localparam logic FN_OPEN  = 1'b1;

    typedef struct packed {
        logic          func;
        logic [10:0]   site_index;
    } t_in;

    typedef struct packed {
        logic          percolates;
        logic          was_open;
        logic          bad_index;
        logic [10:0]   open_count;
    } t_out;

    typedef struct packed {
        logic          is_open;
        logic [AW-1:0] weight;
        logic [AW-1:0] parent;
    } t_word;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHK, S_RDP, S_TSTP, S_DIV, S_NB, S_NBT,
        S_FRD, S_FCK, S_JOIN, S_JOIN2, S_DONE
    } t_state;

    typedef enum logic [1:0] {PH_A, PH_B, PH_T, PH_BOT} t_phase;

    typedef enum logic [1:0] {NB_LEFT, NB_RIGHT, NB_UP, NB_DOWN} t_nbr;

    typedef struct packed {
        logic accept;
        logic clr_start;
        logic clr_step;
        logic set_bad;
        logic set_was;
        logic rd_p;
        logic rd_q;
        logic wr_p_open;
        logic div_step;
        logic nb_next;
        logic ld_x_p;
        logic ld_x_q;
        logic ld_x_top;
        logic ld_x_bot;
        logic x_follow;
        logic save_a;
        logic save_b;
        logic join_w1;
        logic join_w2;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic bad;
        logic clr_last;
        logic rd_open;
        logic div_done;
        logic nb_exists;
        logic nb_last;
        logic at_root;
        logic same_root;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/pso_ctrl.sv */
// Controller state machine that sequences clears, opens, unions and queries.
module pso_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cfg_we,
    input  pso_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output pso_pkg::t_cmd o_cmd
);
    import pso_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= PH_A;
            r_res   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_res   = r_res;
        if (i_cfg_we) begin
            n_state = S_CLEAR;
            n_res   = 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        if (r_res) begin
                            n_state = S_FRD;
                            n_phase = PH_T;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
                S_IDLE: if (i_in_valid) n_state = S_CHK;
                S_CHK: begin
                    if (i_sts.func == FN_CLEAR) begin
                        n_state = S_CLEAR;
                        n_res   = 1'b1;
                    end else if (i_sts.bad) begin
                        n_state = S_FRD;
                        n_phase = PH_T;
                    end else begin
                        n_state = S_RDP;
                    end
                end
                S_RDP: n_state = S_TSTP;
                S_TSTP: begin
                    if (i_sts.rd_open) begin
                        n_state = S_FRD;
                        n_phase = PH_T;
                    end else begin
                        n_state = S_DIV;
                    end
                end
                S_DIV: if (i_sts.div_done) n_state = S_NB;
                S_NB: begin
                    if (i_sts.nb_exists) begin
                        n_state = S_NBT;
                    end else if (i_sts.nb_last) begin
                        n_state = S_FRD;
                        n_phase = PH_T;
                    end
                end
                S_NBT: begin
                    if (i_sts.rd_open) begin
                        n_state = S_FRD;
                        n_phase = PH_A;
                    end else if (i_sts.nb_last) begin
                        n_state = S_FRD;
                        n_phase = PH_T;
                    end else begin
                        n_state = S_NB;
                    end
                end
                S_FRD: n_state = S_FCK;
                S_FCK: begin
                    if (i_sts.at_root) begin
                        unique case (r_phase)
                            PH_A: begin
                                n_phase = PH_B;
                                n_state = S_FRD;
                            end
                            PH_B: n_state = S_JOIN;
                            PH_T: begin
                                n_phase = PH_BOT;
                                n_state = S_FRD;
                            end
                            PH_BOT: n_state = S_DONE;
                            default: n_state = S_DONE;
                        endcase
                    end else begin
                        n_state = S_FRD;
                    end
                end
                S_JOIN: begin
                    if (!i_sts.same_root) begin
                        n_state = S_JOIN2;
                    end else if (i_sts.nb_last) begin
                        n_state = S_FRD;
                        n_phase = PH_T;
                    end else begin
                        n_state = S_NB;
                    end
                end
                S_JOIN2: begin
                    if (i_sts.nb_last) begin
                        n_state = S_FRD;
                        n_phase = PH_T;
                    end else begin
                        n_state = S_NB;
                    end
                end
                S_DONE: if (i_sts.out_free) n_state = S_IDLE;
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE) && !i_cfg_we;
        o_cmd.clr_start = i_cfg_we || ((r_state == S_CHK) && (i_sts.func == FN_CLEAR));
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.ld_x_top = i_sts.clr_last && r_res;
            end
            S_IDLE: o_cmd.accept = i_in_valid && o_in_ready;
            S_CHK: begin
                o_cmd.set_bad  = (i_sts.func == FN_OPEN) && i_sts.bad;
                o_cmd.ld_x_top = (i_sts.func == FN_OPEN) && i_sts.bad;
            end
            S_RDP: o_cmd.rd_p = 1'b1;
            S_TSTP: begin
                o_cmd.set_was   = i_sts.rd_open;
                o_cmd.ld_x_top  = i_sts.rd_open;
                o_cmd.wr_p_open = !i_sts.rd_open;
            end
            S_DIV: o_cmd.div_step = !i_sts.div_done;
            S_NB: begin
                o_cmd.rd_q     = i_sts.nb_exists;
                o_cmd.nb_next  = !i_sts.nb_exists && !i_sts.nb_last;
                o_cmd.ld_x_top = !i_sts.nb_exists && i_sts.nb_last;
            end
            S_NBT: begin
                o_cmd.ld_x_p   = i_sts.rd_open;
                o_cmd.nb_next  = !i_sts.rd_open && !i_sts.nb_last;
                o_cmd.ld_x_top = !i_sts.rd_open && i_sts.nb_last;
            end
            S_FRD: ;
            S_FCK: begin
                if (i_sts.at_root) begin
                    unique case (r_phase)
                        PH_A: begin
                            o_cmd.save_a = 1'b1;
                            o_cmd.ld_x_q = 1'b1;
                        end
                        PH_B: o_cmd.save_b = 1'b1;
                        PH_T: begin
                            o_cmd.save_a   = 1'b1;
                            o_cmd.ld_x_bot = 1'b1;
                        end
                        PH_BOT: o_cmd.save_b = 1'b1;
                        default: o_cmd.save_b = 1'b1;
                    endcase
                end else begin
                    o_cmd.x_follow = 1'b1;
                end
            end
            S_JOIN: begin
                o_cmd.join_w1  = !i_sts.same_root;
                o_cmd.nb_next  = i_sts.same_root && !i_sts.nb_last;
                o_cmd.ld_x_top = i_sts.same_root && i_sts.nb_last;
            end
            S_JOIN2: begin
                o_cmd.join_w2  = 1'b1;
                o_cmd.nb_next  = !i_sts.nb_last;
                o_cmd.ld_x_top = i_sts.nb_last;
            end
            S_DONE: o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

/* rtl/core/pso_dp.sv */
// Datapath with the site store, walk registers, column unit and result register.
module pso_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [pso_pkg::SW-1:0]  i_cfg_wdata,
    input  pso_pkg::t_in            i_in_item,
    input  pso_pkg::t_cmd           i_cmd,
    input  logic                    i_out_ready,
    output pso_pkg::t_sts           o_sts,
    output logic                    o_out_valid,
    output pso_pkg::t_out           o_out_item
);
    import pso_pkg::*;

    t_word         mem [DEPTH];
    t_word         r_rd;
    logic [SW-1:0] r_side;
    logic [AW-1:0] r_cells;
    logic [AW-1:0] r_ci;
    logic [10:0]   r_cnt;
    logic          r_func;
    logic [AW-1:0] r_p, r_q, r_x, r_rem;
    logic [AW-1:0] r_ra, r_wa, r_rb, r_wb;
    logic          r_oa, r_ob;
    t_nbr          r_nbr;
    logic          r_was, r_bad;
    logic          r_ov;
    t_out          r_out;

    logic [SW-1:0]   side_c;
    logic [2*SW-1:0] cells_c;
    logic [AW-1:0]   side_w, bot, bot_lo, q_c, rd_addr, wr_addr;
    logic            nb_ex, we, a_lt_b;
    t_word           wr_data, init_w;

    assign side_w  = {{(AW-SW){1'b0}}, r_side};
    assign bot     = r_cells + 1'b1;
    assign bot_lo  = r_cells - side_w + 1'b1;
    assign a_lt_b  = r_wa < r_wb;
    assign cells_c = side_c * side_c;

    always_comb begin
        if (i_cfg_wdata < SW'(2))             side_c = SW'(2);
        else if (i_cfg_wdata > SW'(MAX_SIDE)) side_c = SW'(MAX_SIDE);
        else                                  side_c = i_cfg_wdata;
    end

    always_comb begin
        unique case (r_nbr)
            NB_LEFT: begin
                nb_ex = r_rem != '0;
                q_c   = r_p - 1'b1;
            end
            NB_RIGHT: begin
                nb_ex = r_rem != side_w - 1'b1;
                q_c   = r_p + 1'b1;
            end
            NB_UP: begin
                nb_ex = r_p > side_w;
                q_c   = r_p - side_w;
            end
            NB_DOWN: begin
                nb_ex = r_p <= r_cells - side_w;
                q_c   = r_p + side_w;
            end
            default: begin
                nb_ex = 1'b0;
                q_c   = r_p;
            end
        endcase
    end

    always_comb begin
        init_w.is_open = 1'b0;
        if (r_ci >= AW'(1) && r_ci <= side_w)        init_w.parent = '0;
        else if (r_ci >= bot_lo && r_ci <= r_cells) init_w.parent = bot;
        else                                         init_w.parent = r_ci;
        if (r_ci == '0 || r_ci == bot) init_w.weight = side_w + 1'b1;
        else                           init_w.weight = AW'(1);
    end

    always_comb begin
        we      = 1'b1;
        wr_addr = r_ci;
        wr_data = init_w;
        priority if (i_cmd.clr_step) begin
            wr_addr = r_ci;
            wr_data = init_w;
        end else if (i_cmd.wr_p_open) begin
            wr_addr = r_p;
            wr_data = '{is_open: 1'b1, weight: r_rd.weight, parent: r_rd.parent};
        end else if (i_cmd.join_w1) begin
            if (a_lt_b) begin
                wr_addr = r_ra;
                wr_data = '{is_open: r_oa, weight: r_wa, parent: r_rb};
            end else begin
                wr_addr = r_rb;
                wr_data = '{is_open: r_ob, weight: r_wb, parent: r_ra};
            end
        end else if (i_cmd.join_w2) begin
            if (a_lt_b) begin
                wr_addr = r_rb;
                wr_data = '{is_open: r_ob, weight: r_wa + r_wb, parent: r_rb};
            end else begin
                wr_addr = r_ra;
                wr_data = '{is_open: r_oa, weight: r_wa + r_wb, parent: r_ra};
            end
        end else begin
            we = 1'b0;
        end
    end

    always_comb begin
        priority if (i_cmd.rd_p) rd_addr = r_p;
        else if (i_cmd.rd_q)     rd_addr = q_c;
        else                     rd_addr = r_x;
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= SW'(MAX_SIDE);
            r_cells <= AW'(MAX_SIDE * MAX_SIDE);
            r_ci    <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_was   <= 1'b0;
            r_bad   <= 1'b0;
            r_nbr   <= NB_LEFT;
        end else begin
            if (i_cfg_we) begin
                r_side  <= side_c;
                r_cells <= cells_c[AW-1:0];
            end
            if (i_cmd.clr_start) begin
                r_ci  <= '0;
                r_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_ci <= r_ci + 1'b1;
            end else if (i_cmd.wr_p_open) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.accept) begin
                r_was <= 1'b0;
                r_bad <= 1'b0;
            end
            if (i_cmd.set_was) r_was <= 1'b1;
            if (i_cmd.set_bad) r_bad <= 1'b1;
            if (i_cmd.wr_p_open)    r_nbr <= NB_LEFT;
            else if (i_cmd.nb_next) r_nbr <= t_nbr'(r_nbr + 1'b1);
            if (i_cmd.out_load)  r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_in_item.func;
            r_p    <= i_in_item.site_index;
        end
        if (i_cmd.wr_p_open)     r_rem <= r_p - 1'b1;
        else if (i_cmd.div_step) r_rem <= r_rem - side_w;
        if (i_cmd.rd_q) r_q <= q_c;
        priority if (i_cmd.ld_x_top) r_x <= '0;
        else if (i_cmd.ld_x_bot)     r_x <= bot;
        else if (i_cmd.ld_x_p)       r_x <= r_p;
        else if (i_cmd.ld_x_q)       r_x <= r_q;
        else if (i_cmd.x_follow)     r_x <= r_rd.parent;
        if (i_cmd.save_a) begin
            r_ra <= r_x;
            r_wa <= r_rd.weight;
            r_oa <= r_rd.is_open;
        end
        if (i_cmd.save_b) begin
            r_rb <= r_x;
            r_wb <= r_rd.weight;
            r_ob <= r_rd.is_open;
        end
        if (i_cmd.out_load) begin
            r_out.percolates <= r_ra == r_rb;
            r_out.was_open   <= r_was;
            r_out.bad_index  <= r_bad;
            r_out.open_count <= r_cnt;
        end
    end

    assign o_sts.func      = r_func;
    assign o_sts.bad       = (r_p == '0) || (r_p > r_cells);
    assign o_sts.clr_last  = r_ci == AW'(DEPTH - 1);
    assign o_sts.rd_open   = r_rd.is_open;
    assign o_sts.div_done  = r_rem < side_w;
    assign o_sts.nb_exists = nb_ex;
    assign o_sts.nb_last   = r_nbr == NB_DOWN;
    assign o_sts.at_root   = r_rd.parent == r_x;
    assign o_sts.same_root = r_ra == r_rb;
    assign o_sts.out_free  = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

endmodule

/* rtl/core/percolation_site_opener.sv */
// Top level of the percolation site opener with union-find connectivity.
// Synchronous reset and every side write run a clearing pass over the whole store with no item taken.
// A clear item runs the same pass; a bad or already open site goes straight to the final query.
// A fresh open marks the site, finds its column by repeated subtraction, then checks each
// neighbor in turn and makes a weighted union with each open one; every parent link followed
// in a union or the final query is one more read of the store. One item is in work at a time.
module percolation_site_opener (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  pso_pkg::t_in            i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output pso_pkg::t_out           o_out_item,
    input  logic                    i_cfg_we,
    input  logic [pso_pkg::SW-1:0]  i_cfg_wdata
);
    import pso_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pso_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_we   (i_cfg_we),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pso_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_in_ready)
        else $error("input taken during clearing pass");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_step, cmd.wr_p_open, cmd.join_w1, cmd.join_w2}))
        else $error("store written from two sources");

    a_join_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.join_w1 |=> cmd.join_w2)
        else $error("union left half done");

endmodule
